[rtl/core/b2da_pkg.sv]
// Package for the binary to decimal ASCII core.
// Holds the sequencer state type, format codes and ASCII constants.
// No dependencies.
package b2da_pkg;

  localparam int unsigned ValueW   = 64;
  localparam int unsigned NumDigits = 20;
  localparam int unsigned BcdW     = 4 * NumDigits;

  localparam logic [1:0] FMT_S32 = 2'd0;
  localparam logic [1:0] FMT_U32 = 2'd1;

  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_MINUS = 8'h2D;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_EMIT
  } b2da_state_e;

endpackage

[rtl/core/binary_to_decimal_ascii_core.sv]
// Binary to decimal ASCII converter, top level and only module.
// Depends on b2da_pkg (state type, format codes, ASCII constants).
//
// A value is taken when start_i is high and busy_o is low. The core then
// runs a bit-serial shift-and-add-3 conversion over all 64 input bits, one
// bit per cycle, drops leading zero digits one per cycle, and sends the text
// one character per cycle, most significant first, with char_valid_o high
// for each beat and last_char_o on the final one. An optional minus sign
// leads. The receiver cannot stall: every beat must be taken as it comes.
// busy_o stays high from acceptance until the last character has been sent.
module binary_to_decimal_ascii_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [1:0]                    req_type_i,
  input  logic [b2da_pkg::ValueW-1:0]   value_i,
  output logic                          char_valid_o,
  output logic [7:0]                    char_code_o,
  output logic                          last_char_o
);
  import b2da_pkg::*;

  localparam int unsigned BitCntW = $clog2(ValueW);
  localparam int unsigned DigCntW = $clog2(NumDigits + 1);

  b2da_state_e        state_q, state_d;
  logic [ValueW-1:0]  bin_q, bin_d;
  logic [BcdW-1:0]    bcd_q, bcd_d;
  logic [BcdW-1:0]    bcd_adj;
  logic [BitCntW-1:0] bit_q, bit_d;
  logic [DigCntW-1:0] dig_q, dig_d;
  logic               neg_q, neg_d;
  logic [3:0]         top_digit;
  logic [31:0]        low_word;
  logic               accept;

  assign accept    = start_i && (state_q == ST_IDLE);
  assign low_word  = value_i[31:0];
  assign top_digit = bcd_q[BcdW-1 -: 4];

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_CONV;
      end
      ST_CONV: begin
        if (bit_q == BitCntW'(ValueW - 1)) state_d = ST_SKIP;
      end
      ST_SKIP: begin
        if (!(top_digit == 4'd0 && dig_q > DigCntW'(1))) begin
          state_d = neg_q ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: state_d = ST_EMIT;
      ST_EMIT: begin
        if (dig_q == DigCntW'(1)) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath next values
  always_comb begin
    bin_d = bin_q;
    bcd_d = bcd_q;
    bit_d = bit_q;
    dig_d = dig_q;
    neg_d = neg_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          bcd_d = '0;
          bit_d = '0;
          dig_d = DigCntW'(NumDigits);
          neg_d = 1'b0;
          if (req_type_i == FMT_S32) begin
            if (low_word[31]) begin
              neg_d = 1'b1;
              bin_d = {32'd0, 32'd0 - low_word};
            end else begin
              bin_d = {32'd0, low_word};
            end
          end else if (req_type_i == FMT_U32) begin
            bin_d = {32'd0, low_word};
          end else begin
            bin_d = value_i;
          end
        end
      end
      ST_CONV: begin
        bcd_d = {bcd_adj[BcdW-2:0], bin_q[ValueW-1]};
        bin_d = {bin_q[ValueW-2:0], 1'b0};
        bit_d = bit_q + BitCntW'(1);
      end
      ST_SKIP: begin
        if (top_digit == 4'd0 && dig_q > DigCntW'(1)) begin
          bcd_d = {bcd_q[BcdW-5:0], 4'd0};
          dig_d = dig_q - DigCntW'(1);
        end
      end
      ST_EMIT: begin
        bcd_d = {bcd_q[BcdW-5:0], 4'd0};
        dig_d = dig_q - DigCntW'(1);
      end
      default: ;
    endcase
  end

  // outputs
  always_comb begin
    busy_o       = (state_q != ST_IDLE);
    char_valid_o = 1'b0;
    char_code_o  = ASCII_ZERO;
    last_char_o  = 1'b0;
    case (state_q)
      ST_SIGN: begin
        char_valid_o = 1'b1;
        char_code_o  = ASCII_MINUS;
      end
      ST_EMIT: begin
        char_valid_o = 1'b1;
        char_code_o  = ASCII_ZERO + {4'd0, top_digit};
        last_char_o  = (dig_q == DigCntW'(1));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      bit_q   <= '0;
      dig_q   <= '0;
      neg_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      bit_q   <= bit_d;
      dig_q   <= dig_d;
      neg_q   <= neg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

`ifndef SYNTHESIS
  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    char_valid_o |-> busy_o)
    else $error("character beat while idle");

  a_last_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_char_o |-> char_valid_o)
    else $error("last flag without a beat");

  a_start_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (state_q == ST_CONV && bit_q == '0))
    else $error("conversion did not start");

  a_emit_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT || state_q == ST_SIGN) |-> (dig_q != '0))
    else $error("digit count ran out while emitting");

  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (char_valid_o && last_char_o) |=> !busy_o)
    else $error("still busy after last beat");
`endif

endmodule
